### rtl/core/lmfs_pkg.sv
// Shared types, codes and helpers for the LED matrix frame store and scanout.
package lmfs_pkg;

    localparam int PANELS_DEF            = 4;
    localparam int COLUMNS_PER_PANEL_DEF = 40;
    localparam int HEIGHT_DEF            = 19;

    localparam int SECTIONS         = 3;
    localparam int ROWS_PER_SECTION = 8;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    typedef enum logic [3:0] {
        PIN_NONE     = 4'd0,
        PIN_LATCH_LO = 4'd1,
        PIN_LATCH_HI = 4'd2,
        PIN_CLK_HI   = 4'd3,
        PIN_CLK_LO   = 4'd4,
        PIN_CLKEN_LO = 4'd5,
        PIN_CLKEN_HI = 4'd6,
        PIN_COLEN_LO = 4'd7,
        PIN_COLEN_HI = 4'd8,
        PIN_DATA_SEL = 4'd9,
        PIN_DATA_PIX = 4'd10,
        PIN_OE_LO    = 4'd11
    } t_pin_op;

    typedef struct packed {
        logic       ld_in;
        logic       clr_wr;
        logic       mem_wr;
        logic       mem_rd;
        logic       rd_scan;
        logic       commit;
        t_pin_op    pin_op;
        logic       pan_clr;
        logic       pan_inc;
        logic       sec_clr;
        logic       sec_inc;
        logic       col_clr;
        logic       col_inc;
        logic       bit_clr;
        logic       bit_inc;
        logic       busy;
        logic       done;
        logic       rd_res;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_range;
        logic bit_last;
        logic col_last;
        logic sec_last;
        logic pan_last;
    } t_stat;

    // Row-select byte: section in the low two bits, one panel line pulled low.
    function automatic logic [7:0] sel_byte(input logic [2:0] panel, input logic [1:0] section);
        logic [5:0] pmask;
        pmask = 6'h3F & ~(6'd1 << (3'd5 - panel));
        return {pmask, section};
    endfunction

endpackage

### rtl/core/led_matrix_frame_scanout_top.sv
// Top level: LED matrix frame store with step-by-step serial refresh scanout.
//
// One beat in gives one beat out. Each item passes the accept, frame store access and
// result steps in that order, and the block takes no new item until the last one has
// left the result step. The next item is accepted while a result still waits, and
// its result is held back until the output register is free. After reset the frame
// store is cleared one pixel a cycle, all PANELS * COLUMNS_PER_PANEL * HEIGHT pixels
// (3040 by default), and no item is accepted until that is done.
// Pin outputs show the levels after the step of the current result beat.
module led_matrix_frame_scanout_top #(
    parameter int PANELS            = lmfs_pkg::PANELS_DEF,
    parameter int COLUMNS_PER_PANEL = lmfs_pkg::COLUMNS_PER_PANEL_DEF,
    parameter int HEIGHT            = lmfs_pkg::HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_x,
    input  logic [4:0] i_y,
    input  logic       i_color,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_latch_pin,
    output logic       o_clock_pin,
    output logic       o_clock_enable_pin,
    output logic       o_column_enable_pin,
    output logic       o_data_pin,
    output logic       o_output_enable_pin,
    output logic       o_busy_res,
    output logic       o_refresh_done,
    output logic       o_read_color,
    output logic [1:0] o_status
);

    lmfs_pkg::t_cmd  cmd;
    lmfs_pkg::t_stat stat;

    lmfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lmfs_datapath #(
        .PANELS            (PANELS),
        .COLUMNS_PER_PANEL (COLUMNS_PER_PANEL),
        .HEIGHT            (HEIGHT)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_x                 (i_x),
        .i_y                 (i_y),
        .i_color             (i_color),
        .o_latch_pin         (o_latch_pin),
        .o_clock_pin         (o_clock_pin),
        .o_clock_enable_pin  (o_clock_enable_pin),
        .o_column_enable_pin (o_column_enable_pin),
        .o_data_pin          (o_data_pin),
        .o_output_enable_pin (o_output_enable_pin),
        .o_busy_res          (o_busy_res),
        .o_refresh_done      (o_refresh_done),
        .o_read_color        (o_read_color),
        .o_status            (o_status)
    );

endmodule

### rtl/core/lmfs_ctrl.sv
// Controller: item handshake sequencing and the refresh step sequencer.
module lmfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_op,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lmfs_pkg::t_stat   i_stat,
    output lmfs_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    typedef enum logic [14:0] {
        P_IDLE          = 15'b000000000000001,
        P_LATCH_LO_BEG  = 15'b000000000000010,
        P_SEL_CLK_HI    = 15'b000000000000100,
        P_SEL_EN_LO     = 15'b000000000001000,
        P_SEL_DATA      = 15'b000000000010000,
        P_SEL_EN_HI     = 15'b000000000100000,
        P_COL_CLK_LO    = 15'b000000001000000,
        P_COLSEL_LO     = 15'b000000010000000,
        P_PIX_EN_LO     = 15'b000000100000000,
        P_PIX_DATA      = 15'b000001000000000,
        P_PIX_EN_HI     = 15'b000010000000000,
        P_COLSEL_HI     = 15'b000100000000000,
        P_LATCH_HI      = 15'b001000000000000,
        P_LATCH_LO_END  = 15'b010000000000000,
        P_OE_LO         = 15'b100000000000000
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [1:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;
    logic       busy;
    logic       out_free;

    assign busy        = (r_phase != P_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.pin_op = lmfs_pkg::PIN_NONE;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ld_in = i_in_valid;
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.mem_rd  = 1'b1;
                o_cmd.rd_scan = (r_op == lmfs_pkg::OP_TICK);
                o_cmd.mem_wr  = (r_op == lmfs_pkg::OP_WRITE) && !busy && i_stat.in_range;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                    unique case (r_op)
                        lmfs_pkg::OP_WRITE: begin
                            if (busy) o_cmd.status = lmfs_pkg::ST_BUSY;
                            else if (!i_stat.in_range) o_cmd.status = lmfs_pkg::ST_RANGE;
                        end
                        lmfs_pkg::OP_READ: begin
                            o_cmd.rd_res = 1'b1;
                            if (!i_stat.in_range) o_cmd.status = lmfs_pkg::ST_RANGE;
                        end
                        lmfs_pkg::OP_START: begin
                            if (busy) o_cmd.status = lmfs_pkg::ST_BUSY;
                            else n_phase = P_LATCH_LO_BEG;
                        end
                        default: begin
                            // tick: one pin step of the refresh sequence, none while idle
                            unique case (r_phase)
                                P_IDLE: ;
                                P_LATCH_LO_BEG: begin
                                    o_cmd.pin_op  = lmfs_pkg::PIN_LATCH_LO;
                                    o_cmd.pan_clr = 1'b1;
                                    o_cmd.sec_clr = 1'b1;
                                    n_phase       = P_SEL_CLK_HI;
                                end
                                P_SEL_CLK_HI: begin
                                    o_cmd.pin_op  = lmfs_pkg::PIN_CLK_HI;
                                    o_cmd.bit_clr = 1'b1;
                                    n_phase       = P_SEL_EN_LO;
                                end
                                P_SEL_EN_LO: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_CLKEN_LO;
                                    n_phase      = P_SEL_DATA;
                                end
                                P_SEL_DATA: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_DATA_SEL;
                                    n_phase      = P_SEL_EN_HI;
                                end
                                P_SEL_EN_HI: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_CLKEN_HI;
                                    if (i_stat.bit_last) begin
                                        n_phase = P_COL_CLK_LO;
                                    end else begin
                                        o_cmd.bit_inc = 1'b1;
                                        n_phase       = P_SEL_EN_LO;
                                    end
                                end
                                P_COL_CLK_LO: begin
                                    o_cmd.pin_op  = lmfs_pkg::PIN_CLK_LO;
                                    o_cmd.col_clr = 1'b1;
                                    n_phase       = P_COLSEL_LO;
                                end
                                P_COLSEL_LO: begin
                                    o_cmd.pin_op  = lmfs_pkg::PIN_COLEN_LO;
                                    o_cmd.bit_clr = 1'b1;
                                    n_phase       = P_PIX_EN_LO;
                                end
                                P_PIX_EN_LO: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_CLKEN_LO;
                                    n_phase      = P_PIX_DATA;
                                end
                                P_PIX_DATA: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_DATA_PIX;
                                    n_phase      = P_PIX_EN_HI;
                                end
                                P_PIX_EN_HI: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_CLKEN_HI;
                                    if (i_stat.bit_last) begin
                                        n_phase = P_COLSEL_HI;
                                    end else begin
                                        o_cmd.bit_inc = 1'b1;
                                        n_phase       = P_PIX_EN_LO;
                                    end
                                end
                                P_COLSEL_HI: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_COLEN_HI;
                                    priority if (!i_stat.col_last) begin
                                        o_cmd.col_inc = 1'b1;
                                        n_phase       = P_COLSEL_LO;
                                    end else if (!i_stat.sec_last) begin
                                        o_cmd.sec_inc = 1'b1;
                                        n_phase       = P_SEL_CLK_HI;
                                    end else if (!i_stat.pan_last) begin
                                        o_cmd.sec_clr = 1'b1;
                                        o_cmd.pan_inc = 1'b1;
                                        n_phase       = P_SEL_CLK_HI;
                                    end else begin
                                        n_phase = P_LATCH_HI;
                                    end
                                end
                                P_LATCH_HI: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_LATCH_HI;
                                    n_phase      = P_LATCH_LO_END;
                                end
                                P_LATCH_LO_END: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_LATCH_LO;
                                    n_phase      = P_OE_LO;
                                end
                                P_OE_LO: begin
                                    o_cmd.pin_op = lmfs_pkg::PIN_OE_LO;
                                    o_cmd.done   = 1'b1;
                                    n_phase      = P_IDLE;
                                end
                                default: n_phase = P_IDLE;
                            endcase
                        end
                    endcase
                    o_cmd.busy = (n_phase != P_IDLE);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= P_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

endmodule

### rtl/core/lmfs_datapath.sv
// Datapath: frame store, scan counters, pin levels and result registers.
module lmfs_datapath #(
    parameter int PANELS            = lmfs_pkg::PANELS_DEF,
    parameter int COLUMNS_PER_PANEL = lmfs_pkg::COLUMNS_PER_PANEL_DEF,
    parameter int HEIGHT            = lmfs_pkg::HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lmfs_pkg::t_cmd    i_cmd,
    output lmfs_pkg::t_stat   o_stat,
    input  logic [7:0]        i_x,
    input  logic [4:0]        i_y,
    input  logic              i_color,
    output logic              o_latch_pin,
    output logic              o_clock_pin,
    output logic              o_clock_enable_pin,
    output logic              o_column_enable_pin,
    output logic              o_data_pin,
    output logic              o_output_enable_pin,
    output logic              o_busy_res,
    output logic              o_refresh_done,
    output logic              o_read_color,
    output logic [1:0]        o_status
);

    localparam int WIDTH = PANELS * COLUMNS_PER_PANEL;
    localparam int DEPTH = WIDTH * HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PANELS > 1) ? $clog2(PANELS) : 1;
    localparam int CW    = (COLUMNS_PER_PANEL > 1) ? $clog2(COLUMNS_PER_PANEL) : 1;

    logic          mem [DEPTH];

    logic [7:0]    r_x;
    logic [4:0]    r_y;
    logic          r_color;
    logic [AW-1:0] r_clr_addr;
    logic [PW-1:0] r_pan;
    logic [1:0]    r_sec;
    logic [CW-1:0] r_col;
    logic [2:0]    r_bit;
    logic          r_q;
    logic          r_rd_ok;
    logic          r_latch, r_clk, r_clken, r_colen, r_data, r_oe;
    logic          r_busy, r_done, r_rd_color;
    logic [1:0]    r_status;

    logic [4:0]    row;
    logic          row_ok;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] scan_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [7:0]    sel;
    logic          pix_bit;

    // ROWS_PER_SECTION is 8, so the row is section and bit side by side
    assign row       = {r_sec, r_bit};
    assign row_ok    = (32'(row) < HEIGHT);
    assign pix_addr  = AW'(32'(r_y) * WIDTH + 32'(r_x));
    assign scan_addr = AW'(32'(row) * WIDTH + 32'(r_pan) * COLUMNS_PER_PANEL + 32'(r_col));

    assign o_stat.in_range = (32'(r_x) < WIDTH) && (32'(r_y) < HEIGHT);
    assign o_stat.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.bit_last = (r_bit == 3'(lmfs_pkg::ROWS_PER_SECTION - 1));
    assign o_stat.col_last = (r_col == CW'(COLUMNS_PER_PANEL - 1));
    assign o_stat.sec_last = (r_sec == 2'(lmfs_pkg::SECTIONS - 1));
    assign o_stat.pan_last = (r_pan == PW'(PANELS - 1));

    assign rd_addr = i_cmd.rd_scan ? scan_addr : pix_addr;
    assign rd_en   = i_cmd.mem_rd && (i_cmd.rd_scan ? row_ok : o_stat.in_range);
    assign wr_en   = i_cmd.clr_wr || i_cmd.mem_wr;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : pix_addr;
    assign wr_data = i_cmd.clr_wr ? 1'b0 : r_color;

    assign sel     = lmfs_pkg::sel_byte(3'(r_pan), r_sec);
    assign pix_bit = r_rd_ok & r_q;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_color <= i_color;
        end
        if (i_cmd.mem_rd) begin
            r_rd_ok <= rd_en;
        end
        if (i_cmd.commit) begin
            r_busy     <= i_cmd.busy;
            r_done     <= i_cmd.done;
            r_rd_color <= i_cmd.rd_res & pix_bit;
            r_status   <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pan      <= '0;
            r_sec      <= '0;
            r_col      <= '0;
            r_bit      <= '0;
            r_latch    <= 1'b0;
            r_clk      <= 1'b0;
            r_clken    <= 1'b0;
            r_colen    <= 1'b0;
            r_data     <= 1'b0;
            r_oe       <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.commit) begin
                if (i_cmd.pan_clr) r_pan <= '0;
                else if (i_cmd.pan_inc) r_pan <= r_pan + PW'(1);
                if (i_cmd.sec_clr) r_sec <= '0;
                else if (i_cmd.sec_inc) r_sec <= r_sec + 2'd1;
                if (i_cmd.col_clr) r_col <= '0;
                else if (i_cmd.col_inc) r_col <= r_col + CW'(1);
                if (i_cmd.bit_clr) r_bit <= '0;
                else if (i_cmd.bit_inc) r_bit <= r_bit + 3'd1;

                unique case (i_cmd.pin_op)
                    lmfs_pkg::PIN_NONE:     ;
                    lmfs_pkg::PIN_LATCH_LO: r_latch <= 1'b0;
                    lmfs_pkg::PIN_LATCH_HI: r_latch <= 1'b1;
                    lmfs_pkg::PIN_CLK_HI:   r_clk   <= 1'b1;
                    lmfs_pkg::PIN_CLK_LO:   r_clk   <= 1'b0;
                    lmfs_pkg::PIN_CLKEN_LO: r_clken <= 1'b0;
                    lmfs_pkg::PIN_CLKEN_HI: r_clken <= 1'b1;
                    lmfs_pkg::PIN_COLEN_LO: r_colen <= 1'b0;
                    lmfs_pkg::PIN_COLEN_HI: r_colen <= 1'b1;
                    lmfs_pkg::PIN_DATA_SEL: r_data  <= sel[r_bit];
                    lmfs_pkg::PIN_DATA_PIX: r_data  <= pix_bit;
                    lmfs_pkg::PIN_OE_LO:    r_oe    <= 1'b0;
                    default:                ;
                endcase
            end
        end
    end

    assign o_latch_pin         = r_latch;
    assign o_clock_pin         = r_clk;
    assign o_clock_enable_pin  = r_clken;
    assign o_column_enable_pin = r_colen;
    assign o_data_pin          = r_data;
    assign o_output_enable_pin = r_oe;
    assign o_busy_res          = r_busy;
    assign o_refresh_done      = r_done;
    assign o_read_color        = r_rd_color;
    assign o_status            = r_status;

endmodule
